// ===== rtl/core/kdne_pkg.sv =====
package kdne_pkg;

    // scanner phases
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_SCAN     = 2'd1,
        PH_DEBOUNCE = 2'd2,
        PH_RELEASE  = 2'd3
    } t_phase;

    // one result transfer
    typedef struct packed {
        logic [3:0]  row_drive;
        logic        key_valid;
        logic [7:0]  key_code;
        logic [26:0] entry_value;
        logic        entry_done;
        logic        digit_dropped;
    } t_result;

    localparam int          MAX_DIGITS     = 8;
    localparam logic [3:0]  COLS_HIGH      = 4'hF;
    localparam logic [3:0]  ROWS_LOW       = 4'h0;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd200;

    // ascii codes of the keys that act
    localparam logic [7:0] KEY_0 = 8'h30;
    localparam logic [7:0] KEY_9 = 8'h39;
    localparam logic [7:0] KEY_A = 8'h41;
    localparam logic [7:0] KEY_B = 8'h42;

    // divide by ten through the reciprocal, exact for any 32-bit value
    localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    // elaboration-time power of ten
    function automatic logic [26:0] pow10(input int n);
        logic [26:0] t;
        t = 27'd1;
        for (int i = 0; i < n; i++) begin
            t = 27'(t * 27'd10);
        end
        return t;
    endfunction

    // a number at or above this already holds the full count of digits
    localparam logic [26:0] FULL_THRESHOLD = pow10(MAX_DIGITS - 1);

    // fixed 4x4 key layout
    function automatic logic [7:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
        logic [7:0] k;
        unique case ({row, col})
            4'h0: k = 8'h31;  // 1
            4'h1: k = 8'h32;  // 2
            4'h2: k = 8'h33;  // 3
            4'h3: k = 8'h34;  // 4
            4'h4: k = 8'h35;  // 5
            4'h5: k = 8'h36;  // 6
            4'h6: k = 8'h37;  // 7
            4'h7: k = 8'h38;  // 8
            4'h8: k = 8'h39;  // 9
            4'h9: k = 8'h2A;  // star
            4'hA: k = 8'h30;  // 0
            4'hB: k = 8'h23;  // hash
            4'hC: k = 8'h41;  // A
            4'hD: k = 8'h42;  // B
            4'hE: k = 8'h43;  // C
            default: k = 8'h44;  // D
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/core/kdne_step.sv =====
module kdne_step
    import kdne_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_advance,
    input  logic [3:0]  i_cols,
    input  logic [15:0] i_debounce_ticks,
    output t_result     o_result
);

    t_phase      r_phase, n_phase;
    logic [1:0]  r_scan_row, n_scan_row;
    logic [7:0]  r_held_key, n_held_key;
    logic [15:0] r_debounce_left, n_debounce_left;
    logic [26:0] r_number, n_number;
    logic [7:0]  r_last_key, n_last_key;

    logic [1:0]  w_low_col;
    logic [1:0]  w_row_inc;
    logic [30:0] w_appended;
    logic [58:0] w_prod;
    logic [26:0] w_tenth;
    logic [3:0]  w_digit;

    // lowest column pulled low
    always_comb begin
        priority if (!i_cols[0]) w_low_col = 2'd0;
        else if (!i_cols[1])     w_low_col = 2'd1;
        else if (!i_cols[2])     w_low_col = 2'd2;
        else if (!i_cols[3])     w_low_col = 2'd3;
        else                     w_low_col = 2'd0;
    end

    // number arithmetic: append a digit, drop the last one
    assign w_row_inc  = r_scan_row + 2'd1;
    assign w_digit    = 4'(r_held_key - KEY_0);
    assign w_appended = {1'b0, r_number, 3'b000} + {3'b000, r_number, 1'b0} + 31'(w_digit);
    assign w_prod     = 59'(r_number) * 59'(DIV10_MAGIC);
    assign w_tenth    = 27'(w_prod >> DIV10_SHIFT);

    // next state and result
    always_comb begin
        n_phase         = r_phase;
        n_scan_row      = r_scan_row;
        n_held_key      = r_held_key;
        n_debounce_left = r_debounce_left;
        n_number        = r_number;
        n_last_key      = r_last_key;
        o_result               = '0;
        o_result.row_drive     = ROWS_LOW;
        o_result.entry_value   = r_number;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_cols != COLS_HIGH) begin
                    n_phase            = PH_SCAN;
                    n_scan_row         = 2'd0;
                    o_result.row_drive = 4'b1110;
                end
            end
            PH_SCAN: begin
                if (i_cols != COLS_HIGH) begin
                    n_held_key      = key_lookup(r_scan_row, w_low_col);
                    n_debounce_left = i_debounce_ticks;
                    n_phase         = PH_DEBOUNCE;
                end else if (r_scan_row == 2'd3) begin
                    n_phase    = PH_IDLE;
                    n_scan_row = 2'd0;
                end else begin
                    n_scan_row         = w_row_inc;
                    o_result.row_drive = ~(4'b0001 << w_row_inc);
                end
            end
            PH_DEBOUNCE: begin
                if (r_debounce_left != 16'd0) begin
                    n_debounce_left = r_debounce_left - 16'd1;
                end else begin
                    o_result.key_valid = 1'b1;
                    n_last_key         = r_held_key;
                    n_phase            = PH_RELEASE;
                    if (r_held_key >= KEY_0 && r_held_key <= KEY_9) begin
                        if (r_number >= FULL_THRESHOLD || w_appended[30:27] != 4'd0) begin
                            o_result.digit_dropped = 1'b1;
                        end else begin
                            n_number             = w_appended[26:0];
                            o_result.entry_value = w_appended[26:0];
                        end
                    end else if (r_held_key == KEY_A) begin
                        o_result.entry_done = 1'b1;
                        n_number            = 27'd0;
                    end else if (r_held_key == KEY_B) begin
                        n_number             = w_tenth;
                        o_result.entry_value = w_tenth;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_RELEASE: begin
                if (i_cols == COLS_HIGH) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        o_result.key_code = n_last_key;
    end

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_scan_row      <= 2'd0;
            r_held_key      <= 8'd0;
            r_debounce_left <= 16'd0;
            r_number        <= 27'd0;
            r_last_key      <= 8'd0;
        end else if (i_advance) begin
            r_phase         <= n_phase;
            r_scan_row      <= n_scan_row;
            r_held_key      <= n_held_key;
            r_debounce_left <= n_debounce_left;
            r_number        <= n_number;
            r_last_key      <= n_last_key;
        end
    end

    // a key only acts at the end of its debounce
    a_valid_after_debounce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.key_valid |-> (r_phase == PH_DEBOUNCE && r_debounce_left == 16'd0))
        else $error("key acted outside debounce end");

    // done and dropped flags come only with an acting key
    a_flags_need_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.entry_done || o_result.digit_dropped) |-> o_result.key_valid)
        else $error("entry flag without key");

    // a confirmed entry clears the number
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_result.entry_done) |=> r_number == 27'd0)
        else $error("number kept after confirm");

endmodule

// ===== rtl/core/kdne_out_buf.sv =====
module kdne_out_buf
    import kdne_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    t_result    r_slot0, r_slot1;
    logic [1:0] r_count;
    logic       w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_slot0;
    assign w_pop   = o_valid && !i_stall;

    // two-entry result queue, head in slot 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            unique case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case ({i_push, w_pop})
            2'b10: begin
                if (r_count == 2'd0) r_slot0 <= i_data;
                else                 r_slot1 <= i_data;
            end
            2'b01: begin
                r_slot0 <= r_slot1;
            end
            2'b11: begin
                if (r_count == 2'd1) begin
                    r_slot0 <= i_data;
                end else begin
                    r_slot0 <= r_slot1;
                    r_slot1 <= i_data;
                end
            end
            default: begin
                r_slot0 <= r_slot0;
            end
        endcase
    end

    // never pushed while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("push into full result queue");

    // fill level stays within two
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result queue count out of range");

    // a held result that is stalled keeps its value
    a_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_data))
        else $error("stalled result changed");

endmodule

// ===== rtl/core/keypad_decimal_number_entry.sv =====
// 4x4 matrix keypad scanner that builds a decimal number. Each input transfer carries one
// sample of the four active-low columns, taken while the rows carried the last row_drive
// given out; each transfer in gives exactly one result transfer. One sample is taken every
// clock when neither side stalls, and each sample passes the input register, then the result
// queue, before its result appears; a two-entry result queue lets sampling go on while a
// result waits. Idle drives all rows low; once a column goes low the rows are driven low
// one per sample, the key is picked from the first row showing a low column, and after
// debounce_ticks further samples it acts: digits append, B drops the last digit, A
// confirms the number and clears it. Digits beyond eight are dropped and flagged.
// debounce_ticks resets to 200 and should be written only while the block is idle.
module keypad_decimal_number_entry
    import kdne_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_column_levels,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_row_drive,
    output logic        o_key_valid,
    output logic [7:0]  o_key_code,
    output logic [26:0] o_entry_value,
    output logic        o_entry_done,
    output logic        o_digit_dropped
);

    logic [15:0] r_debounce_ticks;
    logic        r_in_valid;
    logic [3:0]  r_in_cols;
    logic        w_buf_ready;
    logic        w_advance;
    logic        w_accept;
    t_result     w_result;
    t_result     w_out;

    assign w_advance = r_in_valid && w_buf_ready;
    assign o_stall   = r_in_valid && !w_buf_ready;
    assign w_accept  = i_valid && !o_stall;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            r_debounce_ticks <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_cols <= i_column_levels;
        end
    end

    // scanner step
    kdne_step u_step (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (w_advance),
        .i_cols           (r_in_cols),
        .i_debounce_ticks (r_debounce_ticks),
        .o_result         (w_result)
    );

    // result queue
    kdne_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_advance),
        .i_data  (w_result),
        .o_ready (w_buf_ready),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (w_out)
    );

    assign o_row_drive     = w_out.row_drive;
    assign o_key_valid     = w_out.key_valid;
    assign o_key_code      = w_out.key_code;
    assign o_entry_value   = w_out.entry_value;
    assign o_entry_done    = w_out.entry_done;
    assign o_digit_dropped = w_out.digit_dropped;

    // input stalls only while a sample waits for queue space
    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid)
        else $error("input stalled with empty input register");

    // a waiting sample that cannot advance is kept
    a_sample_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_buf_ready) |=> (r_in_valid && $stable(r_in_cols)))
        else $error("waiting sample lost");

    // a new configuration value lands as written
    a_cfg_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> r_debounce_ticks == $past(i_cfg_data))
        else $error("configuration write lost");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench
    import kdne_pkg::*;
;

    // key layout, row-major, first key in the top byte
    localparam logic [127:0] KEY_LAYOUT = "123456789*0#ABCD";

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = 16'd0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [3:0]  i_column_levels = COLS_HIGH;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [3:0]  o_row_drive;
    logic        o_key_valid;
    logic [7:0]  o_key_code;
    logic [26:0] o_entry_value;
    logic        o_entry_done;
    logic        o_digit_dropped;

    // column samples waiting to go in, and results still owed by the block
    logic [3:0] column_feed [$];
    t_result    due_results [$];

    // own copy of the scanner state
    t_phase      scan_phase;
    logic [1:0]  scan_row_now;
    logic [7:0]  found_key;
    logic [15:0] settle_left;
    logic [26:0] entry_number;
    logic [7:0]  shown_key;
    logic [15:0] settle_ticks;

    int          mismatches = 0;
    int          fed = 0;
    int          debounce_set = 0;
    bit          took = 1'b0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          stall_span = 0;
    int          stall_mode = 0;

    keypad_decimal_number_entry dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_column_levels (i_column_levels),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_row_drive     (o_row_drive),
        .o_key_valid     (o_key_valid),
        .o_key_code      (o_key_code),
        .o_entry_value   (o_entry_value),
        .o_entry_done    (o_entry_done),
        .o_digit_dropped (o_digit_dropped)
    );

    always #5 i_clk = ~i_clk;

    // one scan tick of the keypad: advance state, work out the result
    task scan_tick(input logic [3:0] cols, output t_result r);
        logic [63:0] grown;
        logic [63:0] full_at;
        int          c;
        int          pick;
        r = '0;
        r.row_drive = ROWS_LOW;
        r.entry_value = entry_number;
        full_at = 64'd1;
        for (c = 1; c < MAX_DIGITS; c++) full_at = full_at * 10;
        // lowest column pulled low
        pick = 0;
        for (c = 3; c >= 0; c--) if (!cols[c]) pick = c;
        case (scan_phase)
            PH_IDLE: begin
                if (cols != COLS_HIGH) begin
                    scan_phase = PH_SCAN;
                    scan_row_now = 2'd0;
                    r.row_drive = 4'b1110;
                end
            end
            PH_SCAN: begin
                if (cols != COLS_HIGH) begin
                    found_key = KEY_LAYOUT[127 - 8 * (4 * scan_row_now + pick) -: 8];
                    settle_left = settle_ticks;
                    scan_phase = PH_DEBOUNCE;
                end else if (scan_row_now == 2'd3) begin
                    scan_phase = PH_IDLE;
                    scan_row_now = 2'd0;
                end else begin
                    scan_row_now++;
                    r.row_drive = ~(4'b0001 << scan_row_now);
                end
            end
            PH_DEBOUNCE: begin
                if (settle_left != 16'd0) begin
                    settle_left--;
                end else begin
                    r.key_valid = 1'b1;
                    shown_key = found_key;
                    scan_phase = PH_RELEASE;
                    if (found_key >= KEY_0 && found_key <= KEY_9) begin
                        grown = 64'(entry_number) * 10 + 64'(found_key - KEY_0);
                        if (64'(entry_number) >= full_at || grown > 64'h7FF_FFFF)
                            r.digit_dropped = 1'b1;
                        else
                            entry_number = grown[26:0];
                        r.entry_value = entry_number;
                    end else if (found_key == KEY_A) begin
                        r.entry_done = 1'b1;
                        r.entry_value = entry_number;
                        entry_number = 27'd0;
                    end else if (found_key == KEY_B) begin
                        entry_number = entry_number / 10;
                        r.entry_value = entry_number;
                    end else begin
                        // star, hash, C and D act but do not wait for release
                        scan_phase = PH_IDLE;
                    end
                end
            end
            default: begin
                if (cols == COLS_HIGH) scan_phase = PH_IDLE;
            end
        endcase
        r.key_code = shown_key;
    endtask

    // input side: note each transfer and predict its result
    always @(posedge i_clk) begin : take_side
        t_result r;
        took = i_rst_n && i_valid && !o_stall;
        if (!i_rst_n) begin
            scan_phase = PH_IDLE;
            scan_row_now = 2'd0;
            found_key = 8'd0;
            settle_left = 16'd0;
            entry_number = 27'd0;
            shown_key = 8'd0;
            settle_ticks = DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            settle_ticks = i_cfg_data;
        end
        if (took) begin
            scan_tick(i_column_levels, r);
            due_results.push_back(r);
            void'(column_feed.pop_front());
        end
    end

    // sender: bursts of transfers with gaps between them
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_valid && !took)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (column_feed.size() == 0) begin
                i_valid <= 1'b0;
            end else begin
                i_valid <= 1'b1;
                i_column_levels <= column_feed[0];
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // receiver: stall mode changes every so often
    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_span = $urandom_range(16, 128);
            stall_mode = $urandom_range(0, 3);
        end else begin
            stall_span--;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= ~i_stall;
        endcase
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : check_side
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_row_drive, o_key_valid, o_key_code, o_entry_value,
                   o_entry_done, o_digit_dropped};
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with none predicted: %h", got);
            end else begin
                want = due_results.pop_front();
                if (got.row_drive !== want.row_drive || got.key_valid !== want.key_valid ||
                    got.key_code !== want.key_code || got.entry_value !== want.entry_value ||
                    got.entry_done !== want.entry_done ||
                    got.digit_dropped !== want.digit_dropped) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp rows %h kv %b key %h val %0d done %b drop %b",
                                 want.row_drive, want.key_valid, want.key_code,
                                 want.entry_value, want.entry_done, want.digit_dropped);
                        $display("         got rows %h kv %b key %h val %0d done %b drop %b",
                                 got.row_drive, got.key_valid, got.key_code,
                                 got.entry_value, got.entry_done, got.digit_dropped);
                    end
                end
            end
        end
    end

    // queue one column sample
    task feed(input logic [3:0] v);
        column_feed.push_back(v);
        fed++;
    endtask

    // a full key press at one row and column; quick leaves out idle lead-in and hold
    task add_press(input int row, input int col, input bit quick);
        int         n;
        logic [3:0] hit;
        if (!quick) repeat ($urandom_range(0, 2)) feed(COLS_HIGH);
        feed(quick ? 4'h0 : 4'($urandom_range(0, 14)));
        for (n = 0; n < row; n++) feed(COLS_HIGH);
        // columns below the key stay high, the rest are random
        hit = 4'($urandom_range(0, 15)) | 4'((1 << col) - 1);
        hit[col] = 1'b0;
        feed(hit);
        // debounce and the acting tick, columns ignored
        for (n = 0; n <= debounce_set; n++) feed(4'($urandom_range(0, 15)));
        if (!quick) repeat ($urandom_range(0, 3)) feed(hit);
        feed(COLS_HIGH);
    endtask

    // mostly whole presses, with noise and scans that find nothing
    task random_presses(input int target);
        int start;
        int pick;
        start = fed;
        while (fed - start < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 15) begin
                add_press(($urandom_range(0, 7) == 0) ? 3 : $urandom_range(0, 2),
                          $urandom_range(0, 3), 1'b0);
            end else if (pick < 18) begin
                repeat ($urandom_range(1, 8)) feed(4'($urandom_range(0, 15)));
            end else begin
                feed(4'($urandom_range(0, 14)));
                repeat (4) feed(COLS_HIGH);
            end
        end
    endtask

    // wait until every transfer has been answered and the pipeline is empty
    task drain;
        while (column_feed.size() != 0 || due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task program_debounce(input logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        debounce_set = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset debounce: one digit
        debounce_set = DEBOUNCE_RESET;
        add_press(1, 0, 1'b0);
        drain();

        // directed: confirm, B on zero, a digit, a key that only shows
        program_debounce(16'd0);
        add_press(3, 0, 1'b1);
        add_press(3, 1, 1'b1);
        add_press(0, 3, 1'b1);
        add_press(2, 1, 1'b1);
        drain();

        program_debounce(16'($urandom_range(1, 4)));
        random_presses(750);
        drain();

        program_debounce(16'd0);
        random_presses(750);
        drain();

        // long debounce
        program_debounce(16'd120);
        add_press(1, 2, 1'b0);
        drain();

        if (mismatches == 0 && due_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #25_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/kdne_pkg.sv
rtl/core/kdne_step.sv
rtl/core/kdne_out_buf.sv
rtl/core/keypad_decimal_number_entry.sv
test/testbench.sv
